// ===== hdl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the arp cache learn/lookup core
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int CACHE_ENTRIES_DEF = 64;

    localparam logic [15:0] MIN_FRAME_BYTES = 16'd28;
    localparam logic [15:0] OPCODE_REQUEST  = 16'd1;
    localparam logic [31:0] AGE_INIT        = 32'hFFFF_FFFF;

    // item kinds carried in the input tuser bit
    localparam logic MODE_LOOKUP  = 1'b0;
    localparam logic MODE_RECEIVE = 1'b1;

    // one cache slot as stored in the entry memory
    typedef struct packed {
        logic [31:0] age;
        logic [47:0] mac;
        logic [31:0] ip;
    } entry_t;

    // controller to table
    typedef struct packed {
        logic start;
        logic wr_en;
    } scan_ctl_t;

    // table to controller
    typedef struct packed {
        logic done;
        logic found;
    } scan_sts_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/arpc_table.sv =====
// ----------------------------------------------------------------------------
// arpc_table
// entry memory with a one-entry-per-cycle scan for address match and oldest stamp
// ----------------------------------------------------------------------------
module arpc_table #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(CACHE_ENTRIES),
    parameter int CNT_W         = $clog2(CACHE_ENTRIES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  arpc_pkg::scan_ctl_t  ctl,
    input  logic [31:0]          key_ip,
    input  logic [CNT_W-1:0]     count,
    input  logic [IDX_W-1:0]     wr_addr,
    input  arpc_pkg::entry_t     wr_entry,
    output arpc_pkg::scan_sts_t  sts,
    output logic [IDX_W-1:0]     match_slot,
    output logic [47:0]          match_mac,
    output logic [IDX_W-1:0]     min_slot
);

    arpc_pkg::entry_t mem [CACHE_ENTRIES];

    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic             issuing_reg, issuing_next;
    logic             busy_reg, busy_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    arpc_pkg::entry_t rd_data_reg;

    logic             found_reg, found_next;
    logic [IDX_W-1:0] match_slot_reg, match_slot_next;
    logic [47:0]      match_mac_reg, match_mac_next;
    logic [31:0]      best_age_reg, best_age_next;
    logic [IDX_W-1:0] min_slot_reg, min_slot_next;

    logic             scan_done;
    logic [CNT_W-1:0] issue_inc;

    assign issue_inc = issue_idx_reg + CNT_W'(1);
    assign scan_done = busy_reg & ~issuing_reg & ~rd_vld_reg;

    // memory: one read port for the scan, one write port for the learn
    always_ff @(posedge clk)
    begin
        if (issuing_reg)
        begin
            rd_data_reg <= mem[issue_idx_reg[IDX_W-1:0]];
        end
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_comb
    begin
        issue_idx_next = issue_idx_reg;
        issuing_next   = issuing_reg;
        busy_next      = busy_reg;
        if (ctl.start)
        begin
            issue_idx_next = '0;
            issuing_next   = (count != '0);
            busy_next      = 1'b1;
        end
        else
        begin
            if (issuing_reg)
            begin
                issue_idx_next = issue_inc;
                issuing_next   = (issue_inc < count);
            end
            if (scan_done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // first match in index order, strict minimum of the stamps
    always_comb
    begin
        found_next      = found_reg;
        match_slot_next = match_slot_reg;
        match_mac_next  = match_mac_reg;
        best_age_next   = best_age_reg;
        min_slot_next   = min_slot_reg;
        if (ctl.start)
        begin
            found_next    = 1'b0;
            best_age_next = arpc_pkg::AGE_INIT;
            min_slot_next = '0;
        end
        else if (rd_vld_reg)
        begin
            if (!found_reg && rd_data_reg.ip == key_ip)
            begin
                found_next      = 1'b1;
                match_slot_next = rd_idx_reg;
                match_mac_next  = rd_data_reg.mac;
            end
            if (rd_data_reg.age < best_age_reg)
            begin
                best_age_next = rd_data_reg.age;
                min_slot_next = rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_idx_reg <= '0;
            issuing_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            issue_idx_reg <= issue_idx_next;
            issuing_reg   <= issuing_next;
            busy_reg      <= busy_next;
            rd_vld_reg    <= issuing_reg & ~ctl.start;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= issue_idx_reg[IDX_W-1:0];
        match_slot_reg <= match_slot_next;
        match_mac_reg  <= match_mac_next;
        best_age_reg   <= best_age_next;
        min_slot_reg   <= min_slot_next;
    end

    assign sts.done   = scan_done;
    assign sts.found  = found_reg;
    assign match_slot = match_slot_reg;
    assign match_mac  = match_mac_reg;
    assign min_slot   = min_slot_reg;

endmodule

// ===== hdl/arp_cache_learn_lookup_core.sv =====
// ----------------------------------------------------------------------------
// arp_cache_learn_lookup_core
// ipv4 to mac cache: lookup, learn with oldest-stamp eviction, reply check
// ----------------------------------------------------------------------------
// scan: items other than short frames scan the F slots in use, F = fill count
//   (1..CACHE_ENTRIES, 0 with an empty cache); a short frame skips the scan
// flow: a new item is taken only after the last result has entered the output
//   register; the scan reads one slot per cycle through its single read port
// reset: fill count, age stamp and local_ip clear at once; slots below the fill
//   count are the valid ones, so the entry memory needs no clearing pass
// ----------------------------------------------------------------------------
module arp_cache_learn_lookup_core #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration: local_ip
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // ip_addr[31:0], mac_addr[79:32], dest_ip[111:80], opcode[127:112],
    // frame_length[143:128]
    input  logic [143:0] s_axis_tdata,
    // mode[0]
    input  logic [0:0]   s_axis_tuser,
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found_mac[47:0]
    output logic [47:0]  m_axis_tdata,
    // hit[0], send_reply[1], dropped[2]
    output logic [2:0]   m_axis_tuser
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    // input field unpacking
    logic [31:0] in_ip;
    logic [47:0] in_mac;
    logic [31:0] in_tip;
    logic [15:0] in_op;
    logic [15:0] in_flen;
    logic        in_mode;

    assign in_ip   = s_axis_tdata[31:0];
    assign in_mac  = s_axis_tdata[79:32];
    assign in_tip  = s_axis_tdata[111:80];
    assign in_op   = s_axis_tdata[127:112];
    assign in_flen = s_axis_tdata[143:128];
    assign in_mode = s_axis_tuser[0];

    arpc_pkg::state_t state_reg, state_next;

    logic [31:0]      local_ip_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [31:0]      stamp_reg, stamp_next;

    // item held for the scan
    logic        mode_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;

    // finished result waiting for the output register
    logic        res_hit_reg, res_hit_next;
    logic [47:0] res_mac_reg, res_mac_next;
    logic        res_reply_reg, res_reply_next;
    logic        res_drop_reg, res_drop_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_mac_reg;
    logic [2:0]  out_flags_reg;

    arpc_pkg::scan_ctl_t ctl;
    arpc_pkg::scan_sts_t sts;
    arpc_pkg::entry_t    wr_entry;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    match_slot;
    logic [47:0]         match_mac;
    logic [IDX_W-1:0]    min_slot;

    logic in_xfer;
    logic is_short;
    logic is_learn;
    logic has_room;
    logic ld_out;
    logic out_free;

    assign in_xfer  = s_axis_tvalid & s_axis_tready;
    assign is_short = (in_mode == arpc_pkg::MODE_RECEIVE) && (in_flen < arpc_pkg::MIN_FRAME_BYTES);
    assign is_learn = (mode_reg == arpc_pkg::MODE_RECEIVE);
    assign has_room = (fill_reg < CNT_W'(CACHE_ENTRIES));
    assign out_free = ~out_valid_reg | m_axis_tready;

    // configuration is taken in any cycle
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    // a short frame needs no scan
                    state_next = is_short ? arpc_pkg::ST_DONE : arpc_pkg::ST_SCAN;
                end
            end
            arpc_pkg::ST_SCAN:
            begin
                if (sts.done)
                begin
                    state_next = arpc_pkg::ST_DONE;
                end
            end
            arpc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = arpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the controller
    // ------------------------------------------------------------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        ctl.start     = 1'b0;
        ctl.wr_en     = 1'b0;
        ld_out        = 1'b0;
        case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ctl.start     = s_axis_tvalid & ~is_short;
            end
            arpc_pkg::ST_SCAN:
            begin
                ctl.wr_en = sts.done & is_learn;
            end
            arpc_pkg::ST_DONE:
            begin
                ld_out = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // learn target: matching slot, else first empty slot, else oldest stamp
    always_comb
    begin
        if (sts.found)
        begin
            wr_addr = match_slot;
        end
        else if (has_room)
        begin
            wr_addr = fill_reg[IDX_W-1:0];
        end
        else
        begin
            wr_addr = min_slot;
        end
    end

    assign wr_entry.ip  = ip_reg;
    assign wr_entry.mac = mac_reg;
    assign wr_entry.age = stamp_reg + 32'd1;

    // ------------------------------------------------------------------
    // cache bookkeeping and result capture
    // ------------------------------------------------------------------
    always_comb
    begin
        fill_next      = fill_reg;
        stamp_next     = stamp_reg;
        res_hit_next   = res_hit_reg;
        res_mac_next   = res_mac_reg;
        res_reply_next = res_reply_reg;
        res_drop_next  = res_drop_reg;
        if (in_xfer)
        begin
            res_hit_next   = 1'b0;
            res_mac_next   = '0;
            res_drop_next  = is_short;
            res_reply_next = (in_mode == arpc_pkg::MODE_RECEIVE) && !is_short
                             && (in_op == arpc_pkg::OPCODE_REQUEST)
                             && (in_tip == local_ip_reg);
        end
        if (state_reg == arpc_pkg::ST_SCAN && sts.done)
        begin
            if (is_learn)
            begin
                stamp_next = wr_entry.age;
                if (!sts.found && has_room)
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            else
            begin
                res_hit_next = sts.found;
                res_mac_next = sts.found ? match_mac : 48'd0;
            end
        end
    end

    // the result register accepts a new result whenever the old one leaves
    assign out_valid_next = ld_out | (out_valid_reg & ~m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arpc_pkg::ST_IDLE;
            local_ip_reg  <= '0;
            fill_reg      <= '0;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                local_ip_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg <= in_mode;
            ip_reg   <= in_ip;
            mac_reg  <= in_mac;
        end
        res_hit_reg   <= res_hit_next;
        res_mac_reg   <= res_mac_next;
        res_reply_reg <= res_reply_next;
        res_drop_reg  <= res_drop_next;
        if (ld_out)
        begin
            out_mac_reg   <= res_mac_reg;
            out_flags_reg <= {res_drop_reg, res_reply_reg, res_hit_reg};
        end
    end

    arpc_table #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key_ip     (ip_reg),
        .count      (fill_reg),
        .wr_addr    (wr_addr),
        .wr_entry   (wr_entry),
        .sts        (sts),
        .match_slot (match_slot),
        .match_mac  (match_mac),
        .min_slot   (min_slot)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_mac_reg;
    assign m_axis_tuser  = out_flags_reg;

endmodule

// ===== bench/tb_arp_cache_learn_lookup_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arp_cache_learn_lookup_core
// self-checking bench for the arp cache core: a behavioral cache shadow
// predicts hit, mac, reply and drop for every accepted item, and each result
// transfer is compared in order; lookups, learns, updates, evictions, short
// frames and reply detection run with and without random idling on both streams
// ----------------------------------------------------------------------------
module tb_arp_cache_learn_lookup_core;

    localparam int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF;
    // cycles with no transfer of any kind before the run is declared hung;
    // one item needs at most a full scan plus both sides' longest idling
    localparam int STALL_LIMIT   = 4000;
    // quiet time after the last result, covering one full slot scan
    localparam int SETTLE_CYCLES = CACHE_ENTRIES + 16;

    // one input item as the core sees it
    typedef struct packed {
        logic        mode;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [31:0] dest_ip;
        logic [15:0] opcode;
        logic [15:0] frame_length;
    } arp_item_t;

    // one result item
    typedef struct packed {
        logic        hit;
        logic [47:0] found_mac;
        logic        send_reply;
        logic        dropped;
    } arp_result_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         cfg_valid     = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data      = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // ip_addr[31:0], mac_addr[79:32], dest_ip[111:80], opcode[127:112],
    // frame_length[143:128]
    logic [143:0] s_axis_tdata  = '0;
    // mode[0]
    logic [0:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // found_mac[47:0]
    logic [47:0]  m_axis_tdata;
    // hit[0], send_reply[1], dropped[2]
    logic [2:0]   m_axis_tuser;

    // shadow of the cache contents and the learn stamp counter
    logic        slot_valid [CACHE_ENTRIES];
    logic [31:0] slot_ip    [CACHE_ENTRIES];
    logic [47:0] slot_mac   [CACHE_ENTRIES];
    logic [31:0] slot_age   [CACHE_ENTRIES];
    logic [31:0] stamp_count;
    logic [31:0] local_ip_shadow;

    // predicted results in transfer order
    arp_result_t pending_results [$];
    arp_result_t want_result;

    logic [31:0] addr_pool [256];
    bit          link_no_idle = 1'b0;
    int          error_count  = 0;
    int          sink_wait    = 0;
    int          idle_cycles  = 0;

    arp_cache_learn_lookup_core #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // idle cycles before the next transfer on either stream
    function automatic int draw_gap();
        return link_no_idle ? 0 : int'($urandom_range(0, 7));
    endfunction

    // advance the cache shadow by one item and return what the core must answer
    function automatic arp_result_t predict_cache_result(arp_item_t item);
        arp_result_t res;
        int          slot;
        logic [31:0] oldest;
        res  = '0;
        slot = -1;
        // first valid slot holding the address, used by lookup and learn alike
        for (int i = 0; i < CACHE_ENTRIES && slot < 0; i++)
            if (slot_valid[i] && slot_ip[i] == item.ip_addr)
                slot = i;
        if (item.mode == arpc_pkg::MODE_LOOKUP)
        begin
            if (slot >= 0)
            begin
                res.hit       = 1'b1;
                res.found_mac = slot_mac[slot];
            end
        end
        else if (item.frame_length < arpc_pkg::MIN_FRAME_BYTES)
            res.dropped = 1'b1;
        else
        begin
            // no match: lowest empty slot
            for (int i = 0; i < CACHE_ENTRIES && slot < 0; i++)
                if (!slot_valid[i])
                    slot = i;
            // cache full: lowest slot with the strictly smallest stamp
            if (slot < 0)
            begin
                oldest = arpc_pkg::AGE_INIT;
                slot   = 0;
                for (int i = 0; i < CACHE_ENTRIES; i++)
                    if (slot_age[i] < oldest)
                    begin
                        oldest = slot_age[i];
                        slot   = i;
                    end
            end
            stamp_count      = stamp_count + 32'd1;
            slot_valid[slot] = 1'b1;
            slot_ip[slot]    = item.ip_addr;
            slot_mac[slot]   = item.mac_addr;
            slot_age[slot]   = stamp_count;
            res.send_reply   = (item.opcode == arpc_pkg::OPCODE_REQUEST) &&
                               (item.dest_ip == local_ip_shadow);
        end
        return res;
    endfunction

    // drive one item, hold it until the transfer, then log its prediction;
    // tvalid stays high unless idling is drawn, so items can go back to back
    task automatic send_arp_item(input logic mode, input logic [31:0] ip,
                                 input logic [47:0] mac, input logic [31:0] tip,
                                 input logic [15:0] op, input logic [15:0] flen);
        arp_item_t item;
        int        gap;
        item = '{mode, ip, mac, tip, op, flen};
        gap  = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= item.mode;
        s_axis_tdata  <= {item.frame_length, item.opcode, item.dest_ip,
                          item.mac_addr, item.ip_addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_cache_result(item));
    endtask

    // stop sending and wait until every predicted result has been seen
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // register write, only with the core idle
    task automatic write_local_ip(input logic [31:0] value);
        wait_for_results();
        repeat (CACHE_ENTRIES + 8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid       <= 1'b0;
        local_ip_shadow  = value;
    endtask

    // field extremes, every item kind, short frames, updates and reply decoding
    task automatic test_directed_cases();
        logic [31:0] lip;
        lip = local_ip_shadow;
        // empty cache, ignored fields at both extremes
        send_arp_item(arpc_pkg::MODE_LOOKUP, 32'h0, '1, '1, '1, '1);
        send_arp_item(arpc_pkg::MODE_LOOKUP, '1, '0, lip, arpc_pkg::OPCODE_REQUEST, '0);
        // short frames learn nothing and never reply
        send_arp_item(arpc_pkg::MODE_RECEIVE, 32'h0A00_0005, 48'h0011_2233_4455, lip,
                      arpc_pkg::OPCODE_REQUEST, 16'd0);
        send_arp_item(arpc_pkg::MODE_RECEIVE, 32'h0A00_0005, 48'h0011_2233_4455, lip,
                      arpc_pkg::OPCODE_REQUEST, arpc_pkg::MIN_FRAME_BYTES - 16'd1);
        send_arp_item(arpc_pkg::MODE_LOOKUP, 32'h0A00_0005, '0, '0, '0, '0);
        // shortest accepted frame, request for us
        send_arp_item(arpc_pkg::MODE_RECEIVE, 32'h0A00_0005, 48'h0011_2233_4455, lip,
                      arpc_pkg::OPCODE_REQUEST, arpc_pkg::MIN_FRAME_BYTES);
        send_arp_item(arpc_pkg::MODE_LOOKUP, 32'h0A00_0005, '0, '0, '0, '0);
        // non-request opcodes and foreign targets give no reply
        send_arp_item(arpc_pkg::MODE_RECEIVE, 32'h0, '1, lip, 16'd2, '1);
        send_arp_item(arpc_pkg::MODE_RECEIVE, '1, '0, lip ^ 32'd1,
                      arpc_pkg::OPCODE_REQUEST, 16'd60);
        send_arp_item(arpc_pkg::MODE_RECEIVE, 32'h0A00_0006, 48'hA5A5_5A5A_F00F, lip,
                      16'h0101, 16'd42);
        send_arp_item(arpc_pkg::MODE_RECEIVE, 32'h0A00_0007, 48'h8000_0000_0001, lip,
                      '1, 16'd28);
        send_arp_item(arpc_pkg::MODE_RECEIVE, 32'h0A00_0008, 48'h0000_0000_0001, '1,
                      16'd0, 16'd64);
        send_arp_item(arpc_pkg::MODE_RECEIVE, 32'h0A00_000A, 48'h7FFF_FFFF_FFFE, '0,
                      arpc_pkg::OPCODE_REQUEST, 16'd64);
        // hits at the address extremes, lookup ignores request fields
        send_arp_item(arpc_pkg::MODE_LOOKUP, 32'h0, '0, '0, '0, '0);
        send_arp_item(arpc_pkg::MODE_LOOKUP, '1, '1, lip, arpc_pkg::OPCODE_REQUEST, '0);
        // update of a known address
        send_arp_item(arpc_pkg::MODE_RECEIVE, 32'h0, 48'h0123_4567_89AB, lip,
                      arpc_pkg::OPCODE_REQUEST, 16'd28);
        send_arp_item(arpc_pkg::MODE_LOOKUP, 32'h0, '0, '0, '0, '0);
        send_arp_item(arpc_pkg::MODE_LOOKUP, 32'h0A00_0009, '0, '0, '0, '0);
        // a dropped frame must not overwrite the stored mac
        send_arp_item(arpc_pkg::MODE_RECEIVE, 32'h0A00_0005, 48'hDEAD_BEEF_0000, lip,
                      arpc_pkg::OPCODE_REQUEST, 16'd20);
        send_arp_item(arpc_pkg::MODE_LOOKUP, 32'h0A00_0005, '0, '0, '0, '0);
    endtask

    // random mix over a pool of addresses; a pool larger than the cache forces
    // evictions, a smaller one keeps it busy with updates and hits
    task automatic test_random_traffic(input int count, input int pool_size,
                                       input bit no_idle, input bit pause_midway);
        int          pick;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] tip;
        logic [15:0] op;
        logic [15:0] flen;
        for (int i = 0; i < pool_size; i++)
            addr_pool[i] = $urandom;
        link_no_idle = no_idle;
        for (int n = 0; n < count; n++)
        begin
            if (pause_midway && n == count / 2)
                wait_for_results();
            pick = $urandom_range(0, 99);
            ip   = ($urandom_range(0, 4) == 0) ? $urandom
                                               : addr_pool[$urandom_range(0, pool_size - 1)];
            mac  = {16'($urandom), $urandom};
            case ($urandom_range(0, 3))
                0, 1:    op = arpc_pkg::OPCODE_REQUEST;
                2:       op = 16'd2;
                default: op = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0, 1:    tip = local_ip_shadow;
                2:       tip = local_ip_shadow ^ (32'd1 << $urandom_range(0, 31));
                default: tip = $urandom;
            endcase
            if (pick < 90)
                flen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(28, 65535))
                                                   : 16'($urandom_range(28, 64));
            else
                flen = 16'($urandom_range(0, 27));
            send_arp_item((pick < 45) ? arpc_pkg::MODE_LOOKUP : arpc_pkg::MODE_RECEIVE,
                          ip, mac, tip, op, flen);
        end
        link_no_idle = 1'b0;
    endtask

    // result sink: random stalls while a result waits, checks each transfer
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no item outstanding");
                    error_count++;
                end
                else
                begin
                    want_result = pending_results.pop_front();
                    if (m_axis_tuser[0] !== want_result.hit)
                    begin
                        $error("hit: expected %0d, actual %0d",
                               want_result.hit, m_axis_tuser[0]);
                        error_count++;
                    end
                    if (m_axis_tdata !== want_result.found_mac)
                    begin
                        $error("found_mac: expected %h, actual %h",
                               want_result.found_mac, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser[1] !== want_result.send_reply)
                    begin
                        $error("send_reply: expected %0d, actual %0d",
                               want_result.send_reply, m_axis_tuser[1]);
                        error_count++;
                    end
                    if (m_axis_tuser[2] !== want_result.dropped)
                    begin
                        $error("dropped: expected %0d, actual %0d",
                               want_result.dropped, m_axis_tuser[2]);
                        error_count++;
                    end
                end
                sink_wait = draw_gap();
            end
            // stall counts down only while a result is offered
            else if (m_axis_tvalid && sink_wait > 0)
                sink_wait = sink_wait - 1;
            m_axis_tready <= (sink_wait == 0);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        // shadow starts from the reset state of the core
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_ip[i]    = '0;
            slot_mac[i]   = '0;
            slot_age[i]   = '0;
        end
        stamp_count     = '0;
        local_ip_shadow = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_local_ip(32'hC0A8_0001);
        test_directed_cases();
        // all-zero local address, update-heavy pool
        write_local_ip(32'h0000_0000);
        test_random_traffic(500, 48, 1'b0, 1'b0);
        // all-ones local address, eviction-heavy pool, pause until drained
        write_local_ip(32'hFFFF_FFFF);
        test_random_traffic(400, 160, 1'b0, 1'b1);
        // back-to-back transfers with no idling on either side
        write_local_ip($urandom);
        test_random_traffic(300, 96, 1'b1, 1'b0);
        write_local_ip($urandom);
        test_random_traffic(750, 96, 1'b0, 1'b1);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== arp_cache_learn_lookup_core.f =====
hdl/arpc_pkg.sv
hdl/arpc_table.sv
hdl/arp_cache_learn_lookup_core.sv
bench/tb_arp_cache_learn_lookup_core.sv
